FILE: hdl/ltad_pkg.sv
// ----------------------------------------------------------------------------
// ltad_pkg
// Shared constants, register indexes and stage records for the lead aim block.
// ----------------------------------------------------------------------------
package ltad_pkg;

    localparam int unsigned ISQRT_STAGES = 32;
    localparam int unsigned TDIV_STAGES  = 48;
    localparam int unsigned NDIV_QBITS   = 15;
    localparam int unsigned NDIV_STAGES  = NDIV_QBITS + 1;
    localparam int unsigned SA_DELAY     = ISQRT_STAGES + TDIV_STAGES;

    localparam logic CFG_SPEED  = 1'b0;
    localparam logic CFG_MUZZLE = 1'b1;

    localparam logic [23:0] SPEED_RESET  = 24'd256000;
    localparam logic [15:0] MUZZLE_RESET = 16'd25600;

    typedef struct packed {
        logic [2:0][32:0] dr;
        logic [2:0][31:0] vm;
        logic [2:0]       vneg;
        logic [31:0]      cz;
    } side_a_t;

    typedef struct packed {
        logic [2:0][48:0] am;
        logic [2:0]       aneg;
        logic [31:0]      cz;
    } side_m_t;

    typedef struct packed {
        logic [2:0][30:0] am;
        logic [2:0]       aneg;
        logic [31:0]      cz;
    } side_b_t;

    typedef struct packed {
        logic [2:0]  aneg;
        logic [31:0] cz;
    } side_c_t;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
            r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: hdl/ltad_if.sv
// ----------------------------------------------------------------------------
// ltad_if
// Request and result channels of the lead aim block.
// ----------------------------------------------------------------------------
interface ltad_target_if;
    logic               valid;
    logic               ready;
    logic               target_valid;
    logic signed [31:0] shooter_x;
    logic signed [31:0] shooter_y;
    logic signed [31:0] shooter_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_vx;
    logic signed [31:0] target_vy;
    logic signed [31:0] target_vz;

    modport source (
        output valid, target_valid, shooter_x, shooter_y, shooter_z,
        output target_x, target_y, target_z, target_vx, target_vy, target_vz,
        input  ready
    );
    modport sink (
        input  valid, target_valid, shooter_x, shooter_y, shooter_z,
        input  target_x, target_y, target_z, target_vx, target_vy, target_vz,
        output ready
    );
endinterface

interface ltad_aim_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] aim_x;
    logic signed [15:0] aim_y;
    logic signed [15:0] aim_z;
    logic signed [31:0] muzzle_z;
    logic               degenerate;

    modport source (
        output valid, aim_x, aim_y, aim_z, muzzle_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, aim_x, aim_y, aim_z, muzzle_z, degenerate,
        output ready
    );
endinterface

FILE: hdl/ltad_isqrt.sv
// ----------------------------------------------------------------------------
// ltad_isqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ltad_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [63:0] rad,
    output logic        out_vld,
    output logic [31:0] root
);

    logic        vld_reg  [ltad_pkg::ISQRT_STAGES];
    logic [33:0] rem_reg  [ltad_pkg::ISQRT_STAGES];
    logic [31:0] root_reg [ltad_pkg::ISQRT_STAGES];
    logic [63:0] rad_reg  [ltad_pkg::ISQRT_STAGES];

    for (genvar j = 0; j < ltad_pkg::ISQRT_STAGES; j++)
    begin : g_stage
        logic        vld_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [35:0] cur;
        logic [35:0] trial;
        logic        take;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (j == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign rad_in  = rad_reg[j-1];
        end

        assign cur       = {rem_in, rad_in[63:62]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign take      = (cur >= trial);
        assign rem_next  = take ? 34'(cur - trial) : cur[33:0];
        assign root_next = {root_in[30:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= {rad_in[61:0], 2'b00};
            end
        end
    end

    assign out_vld = vld_reg[ltad_pkg::ISQRT_STAGES-1];
    assign root    = root_reg[ltad_pkg::ISQRT_STAGES-1];

endmodule

FILE: hdl/ltad_tdiv.sv
// ----------------------------------------------------------------------------
// ltad_tdiv
// Pipelined restoring divider for the flight time, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ltad_tdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [31:0] dist_root,
    input  logic [23:0] divisor,
    output logic        out_vld,
    output logic [47:0] quot
);

    logic        vld_reg [ltad_pkg::TDIV_STAGES];
    logic [23:0] rem_reg [ltad_pkg::TDIV_STAGES];
    logic [47:0] num_reg [ltad_pkg::TDIV_STAGES];
    logic [47:0] q_reg   [ltad_pkg::TDIV_STAGES];

    for (genvar j = 0; j < ltad_pkg::TDIV_STAGES; j++)
    begin : g_stage
        logic        vld_in;
        logic [23:0] rem_in;
        logic [47:0] num_in;
        logic [47:0] q_in;
        logic [24:0] cur;
        logic        take;
        logic [23:0] rem_next;

        if (j == 0)
        begin : g_first
            assign vld_in = in_vld;
            assign rem_in = '0;
            assign num_in = {dist_root, 16'h0000};
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign cur      = {rem_in, num_in[47]};
        assign take     = (cur >= {1'b0, divisor});
        assign rem_next = take ? 24'(cur - {1'b0, divisor}) : cur[23:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                num_reg[j] <= {num_in[46:0], 1'b0};
                q_reg[j]   <= {q_in[46:0], take};
            end
        end
    end

    assign out_vld = vld_reg[ltad_pkg::TDIV_STAGES-1];
    assign quot    = q_reg[ltad_pkg::TDIV_STAGES-1];

endmodule

FILE: hdl/ltad_ndiv.sv
// ----------------------------------------------------------------------------
// ltad_ndiv
// Three-lane pipelined divider that scales the aim components to Q1.14.
// ----------------------------------------------------------------------------
module ltad_ndiv (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [2:0][30:0] am,
    input  logic [31:0]      len,
    output logic             out_vld,
    output logic [2:0][14:0] quot,
    output logic [31:0]      len_out
);

    logic             vld_reg [ltad_pkg::NDIV_STAGES];
    logic [31:0]      len_reg [ltad_pkg::NDIV_STAGES];
    logic [2:0][31:0] rem_reg [ltad_pkg::NDIV_STAGES];
    logic [2:0][14:0] lo_reg  [ltad_pkg::NDIV_STAGES];
    logic [2:0][14:0] q_reg   [ltad_pkg::NDIV_STAGES];

    // The first stage forms am * 16384 + len / 2; its upper bits are below len.
    for (genvar i = 0; i < 3; i++)
    begin : g_prep
        logic [45:0] dividend;

        assign dividend = 46'({am[i], 14'h0000}) + 46'(len[31:1]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0][i] <= {1'b0, dividend[45:15]};
                lo_reg[0][i]  <= dividend[14:0];
                q_reg[0][i]   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            len_reg[0] <= len;
    end

    for (genvar j = 1; j < ltad_pkg::NDIV_STAGES; j++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                len_reg[j] <= len_reg[j-1];
        end

        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [32:0] cur;
            logic        take;
            logic [31:0] rem_next;

            assign cur      = {rem_reg[j-1][i], lo_reg[j-1][i][14]};
            assign take     = (cur >= {1'b0, len_reg[j-1]});
            assign rem_next = take ? 32'(cur - {1'b0, len_reg[j-1]}) : cur[31:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j][i] <= rem_next;
                    lo_reg[j][i]  <= {lo_reg[j-1][i][13:0], 1'b0};
                    q_reg[j][i]   <= {q_reg[j-1][i][13:0], take};
                end
            end
        end
    end

    assign out_vld = vld_reg[ltad_pkg::NDIV_STAGES-1];
    assign quot    = q_reg[ltad_pkg::NDIV_STAGES-1];
    assign len_out = len_reg[ltad_pkg::NDIV_STAGES-1];

endmodule

FILE: hdl/lead_target_aim_direction.sv
// ----------------------------------------------------------------------------
// lead_target_aim_direction
// First-order lead prediction: unit aim vector toward the predicted target.
// ----------------------------------------------------------------------------
// Requests arrive on the target channel and results leave on the aim channel,
// both valid/ready. A request with target_valid low is taken and dropped.
// The two settings (projectile speed, muzzle height) are written through the
// cfg_we/cfg_idx/cfg_wdata port; the user must write them only while no
// request is in flight, as the block itself does not enforce this. The two
// 32-stage square roots, the 48-stage flight time divider and the 16-stage
// normalizing divider make up most of the pipeline. One request can enter
// every cycle while the pipeline is not held. All stages move together; when
// the result register is full and the receiver holds ready low, the whole
// pipeline holds and ready drops on the target channel, so nothing is lost
// or repeated. Reset clears every valid bit and loads the default settings.
// ----------------------------------------------------------------------------
module lead_target_aim_direction (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_idx,
    input  logic [23:0]      cfg_wdata,
    ltad_target_if.sink      target,
    ltad_aim_if.source       aim
);

    logic [23:0] speed_reg;
    logic [15:0] muzzle_reg;
    logic [23:0] divisor;
    logic        pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= ltad_pkg::SPEED_RESET;
            muzzle_reg <= ltad_pkg::MUZZLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                ltad_pkg::CFG_SPEED:  speed_reg  <= cfg_wdata;
                ltad_pkg::CFG_MUZZLE: muzzle_reg <= cfg_wdata[15:0];
                default:              speed_reg  <= speed_reg;
            endcase
        end
    end

    assign divisor = (speed_reg == '0) ? 24'd1 : speed_reg;

    logic out_vld_reg;

    assign pipe_en      = !out_vld_reg || aim.ready;
    assign target.ready = pipe_en;

    // Stage 1: launch point, offsets and velocity magnitudes.
    logic [2:0][31:0]  tg;
    logic [2:0][31:0]  cc;
    logic [2:0][31:0]  vv;
    logic [2:0][31:0]  m_next;
    ltad_pkg::side_a_t s1_side_next;

    always_comb
    begin
        logic [31:0] sd;
        tg = {target.target_z, target.target_y, target.target_x};
        vv = {target.target_vz, target.target_vy, target.target_vx};
        cc[0] = target.shooter_x;
        cc[1] = target.shooter_y;
        cc[2] = ltad_pkg::sat32({target.shooter_z[31], target.shooter_z}
                                + {17'h0, muzzle_reg});
        s1_side_next.cz = cc[2];
        for (int i = 0; i < 3; i++)
        begin
            s1_side_next.dr[i]   = {tg[i][31], tg[i]} - {cc[i][31], cc[i]};
            sd                   = ltad_pkg::sat32(s1_side_next.dr[i]);
            m_next[i]            = sd[31] ? 32'(-sd) : sd;
            s1_side_next.vneg[i] = vv[i][31];
            s1_side_next.vm[i]   = vv[i][31] ? 32'(-vv[i]) : vv[i];
        end
    end

    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [2:0][31:0]  s1_m_reg;
    logic [2:0][63:0]  s2_sq_reg;
    logic [63:0]       s3_sum_reg;
    ltad_pkg::side_a_t s1_side_reg, s2_side_reg, s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_vld_reg <= target.valid && target.target_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_m_reg    <= m_next;
            s1_side_reg <= s1_side_next;
            for (int i = 0; i < 3; i++)
                s2_sq_reg[i] <= s1_m_reg[i] * s1_m_reg[i];
            s2_side_reg <= s1_side_reg;
            s3_sum_reg  <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_side_reg <= s2_side_reg;
        end
    end

    // Distance, then flight time.
    logic        dist_vld;
    logic [31:0] dist_root;
    logic        tdiv_vld;
    logic [47:0] tquot;

    ltad_isqrt u_dist_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (s3_vld_reg),
        .rad     (s3_sum_reg),
        .out_vld (dist_vld),
        .root    (dist_root)
    );

    ltad_tdiv u_time_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (dist_vld),
        .dist_root (dist_root),
        .divisor   (divisor),
        .out_vld   (tdiv_vld),
        .quot      (tquot)
    );

    ltad_pkg::side_a_t sa_pipe_reg [ltad_pkg::SA_DELAY];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sa_pipe_reg[0] <= s3_side_reg;
            for (int k = 1; k < ltad_pkg::SA_DELAY; k++)
                sa_pipe_reg[k] <= sa_pipe_reg[k-1];
        end
    end

    // Stages 4 to 11: lead offset, aim vector, block scaling, squared length.
    logic              s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic              s8_vld_reg, s9_vld_reg, s10_vld_reg, s11_vld_reg;
    logic [31:0]       s4_t_reg;
    logic [2:0][63:0]  s5_prod_reg;
    ltad_pkg::side_a_t s4_side_reg, s5_side_reg;
    ltad_pkg::side_m_t s6_side_next;
    ltad_pkg::side_m_t s6_side_reg, s7_side_reg, s8_side_reg;
    logic [48:0]       s7_max_reg;
    logic [48:0]       max_next;
    logic [4:0]        s8_sh_reg;
    logic [4:0]        sh_next;
    ltad_pkg::side_b_t s9_side_next;
    ltad_pkg::side_b_t s9_side_reg, s10_side_reg, s11_side_reg;
    logic [2:0][61:0]  s10_sq_reg;
    logic [63:0]       s11_sum_reg;

    always_comb
    begin
        logic [49:0] off;
        logic [49:0] a;
        s6_side_next.cz = s5_side_reg.cz;
        for (int i = 0; i < 3; i++)
        begin
            off = {2'b00, s5_prod_reg[i][63:16]};
            a   = {{17{s5_side_reg.dr[i][32]}}, s5_side_reg.dr[i]}
                  + (s5_side_reg.vneg[i] ? 50'(-off) : off);
            s6_side_next.aneg[i] = a[49];
            s6_side_next.am[i]   = a[49] ? 49'(-a) : a[48:0];
        end
    end

    always_comb
    begin
        max_next = s6_side_reg.am[0];
        if (s6_side_reg.am[1] > max_next)
            max_next = s6_side_reg.am[1];
        if (s6_side_reg.am[2] > max_next)
            max_next = s6_side_reg.am[2];
    end

    always_comb
    begin
        sh_next = '0;
        for (int p = 31; p < 49; p++)
        begin
            if (s7_max_reg[p])
                sh_next = 5'(p - 30);
        end
    end

    always_comb
    begin
        logic [48:0] shifted;
        s9_side_next.cz   = s8_side_reg.cz;
        s9_side_next.aneg = s8_side_reg.aneg;
        for (int i = 0; i < 3; i++)
        begin
            shifted              = s8_side_reg.am[i] >> s8_sh_reg;
            s9_side_next.am[i]   = shifted[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s4_vld_reg  <= tdiv_vld;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            s11_vld_reg <= s10_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_t_reg    <= (tquot[47:32] != '0) ? 32'hffff_ffff : tquot[31:0];
            s4_side_reg <= sa_pipe_reg[ltad_pkg::SA_DELAY-1];
            for (int i = 0; i < 3; i++)
                s5_prod_reg[i] <= s4_side_reg.vm[i] * s4_t_reg;
            s5_side_reg  <= s4_side_reg;
            s6_side_reg  <= s6_side_next;
            s7_max_reg   <= max_next;
            s7_side_reg  <= s6_side_reg;
            s8_sh_reg    <= sh_next;
            s8_side_reg  <= s7_side_reg;
            s9_side_reg  <= s9_side_next;
            for (int i = 0; i < 3; i++)
                s10_sq_reg[i] <= s9_side_reg.am[i] * s9_side_reg.am[i];
            s10_side_reg <= s9_side_reg;
            s11_sum_reg  <= 64'(s10_sq_reg[0]) + 64'(s10_sq_reg[1])
                            + 64'(s10_sq_reg[2]);
            s11_side_reg <= s10_side_reg;
        end
    end

    // Aim length and normalization.
    logic              len_vld;
    logic [31:0]       len;
    logic              ndiv_vld;
    logic [2:0][14:0]  nquot;
    logic [31:0]       nlen;
    ltad_pkg::side_b_t sb_pipe_reg [ltad_pkg::ISQRT_STAGES];
    ltad_pkg::side_c_t sc_pipe_reg [ltad_pkg::NDIV_STAGES];

    ltad_isqrt u_len_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (s11_vld_reg),
        .rad     (s11_sum_reg),
        .out_vld (len_vld),
        .root    (len)
    );

    ltad_ndiv u_norm_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .in_vld  (len_vld),
        .am      (sb_pipe_reg[ltad_pkg::ISQRT_STAGES-1].am),
        .len     (len),
        .out_vld (ndiv_vld),
        .quot    (nquot),
        .len_out (nlen)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sb_pipe_reg[0] <= s11_side_reg;
            for (int k = 1; k < ltad_pkg::ISQRT_STAGES; k++)
                sb_pipe_reg[k] <= sb_pipe_reg[k-1];
            sc_pipe_reg[0].aneg <= sb_pipe_reg[ltad_pkg::ISQRT_STAGES-1].aneg;
            sc_pipe_reg[0].cz   <= sb_pipe_reg[ltad_pkg::ISQRT_STAGES-1].cz;
            for (int k = 1; k < ltad_pkg::NDIV_STAGES; k++)
                sc_pipe_reg[k] <= sc_pipe_reg[k-1];
        end
    end

    // Result register.
    logic [2:0][15:0] aim_reg;
    logic [2:0][15:0] aim_next;
    logic [31:0]      muzzle_z_reg;
    logic             degenerate_reg;
    logic             zero_len;

    assign zero_len = (nlen == '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_len)
                aim_next[i] = '0;
            else if (sc_pipe_reg[ltad_pkg::NDIV_STAGES-1].aneg[i])
                aim_next[i] = 16'(-{1'b0, nquot[i]});
            else
                aim_next[i] = {1'b0, nquot[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (pipe_en)
            out_vld_reg <= ndiv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && ndiv_vld)
        begin
            aim_reg        <= aim_next;
            muzzle_z_reg   <= sc_pipe_reg[ltad_pkg::NDIV_STAGES-1].cz;
            degenerate_reg <= zero_len;
        end
    end

    assign aim.valid      = out_vld_reg;
    assign aim.aim_x      = aim_reg[0];
    assign aim.aim_y      = aim_reg[1];
    assign aim.aim_z      = aim_reg[2];
    assign aim.muzzle_z   = muzzle_z_reg;
    assign aim.degenerate = degenerate_reg;

endmodule

FILE: hdl/ltad_checker.sv
// ----------------------------------------------------------------------------
// ltad_checker
// Port-level checks on the lead aim block, attached to the top level.
// ----------------------------------------------------------------------------
module ltad_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               tgt_ready,
    input logic               aim_valid,
    input logic               aim_ready,
    input logic signed [15:0] aim_x,
    input logic signed [15:0] aim_y,
    input logic signed [15:0] aim_z,
    input logic signed [31:0] muzzle_z,
    input logic               degenerate
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        aim_valid && !aim_ready |=> aim_valid && $stable(aim_x) && $stable(aim_y)
            && $stable(aim_z) && $stable(muzzle_z) && $stable(degenerate))
    else $error("stalled aim result changed");

    // With the result register empty, the block takes requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        !aim_valid |-> tgt_ready)
    else $error("request refused while result register empty");

    // A zero-length aim gives a zero vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        aim_valid && degenerate |-> aim_x == 16'sd0 && aim_y == 16'sd0 && aim_z == 16'sd0)
    else $error("degenerate result with nonzero aim");

    // Components of a unit vector stay within one in Q1.14.
    assert property (@(posedge clk) disable iff (!rst_n)
        aim_valid |-> aim_x <= 16'sd16384 && aim_x >= -16'sd16384
            && aim_y <= 16'sd16384 && aim_y >= -16'sd16384
            && aim_z <= 16'sd16384 && aim_z >= -16'sd16384)
    else $error("aim component out of range");

endmodule

bind lead_target_aim_direction ltad_checker u_ltad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tgt_ready  (target.ready),
    .aim_valid  (aim.valid),
    .aim_ready  (aim.ready),
    .aim_x      (aim.aim_x),
    .aim_y      (aim.aim_y),
    .aim_z      (aim.aim_z),
    .muzzle_z   (aim.muzzle_z),
    .degenerate (aim.degenerate)
);

FILE: bench/lead_target_aim_direction_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lead_target_aim_direction_tb
// Self-checking bench for the lead aim block.
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, dropped requests, a zero aim
// and a saturated launch height. Random requests follow over several
// register settings. Both channels idle at random. A golden model predicts
// every result, and each accepted result is compared with the oldest one.
// ----------------------------------------------------------------------------
module lead_target_aim_direction_tb;

    typedef struct packed {
        logic        tv;
        logic [31:0] sx, sy, sz, tx, ty, tz, vx, vy, vz;
    } req_t;

    typedef struct packed {
        logic [15:0] ax, ay, az;
        logic [31:0] mz;
        logic        dg;
    } aim_t;

    typedef struct {
        req_t r;
        logic chk;
        aim_t e;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_idx = ltad_pkg::CFG_SPEED;
    logic [23:0] cfg_wdata = '0;

    ltad_target_if target ();
    ltad_aim_if aim ();

    lead_target_aim_direction dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata), .target(target.sink), .aim(aim.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    logic [23:0] speed_q = ltad_pkg::SPEED_RESET;
    logic [15:0] height_q = ltad_pkg::MUZZLE_RESET;
    aim_t expected_aims[$];
    int errors = 0;
    int n_results = 0;
    int n_degenerate = 0;
    int hold_off = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic aim_t predict_aim(input req_t r);
        longint c[3], tg[3], v[3], a[3], o;
        logic [63:0] am[3], sq, dist_v, spd, t, maxm, len, m, off;
        int i, s;
        aim_t e;
        c[0] = longint'($signed(r.sx));
        c[1] = longint'($signed(r.sy));
        c[2] = clamp32(longint'($signed(r.sz)) + longint'(height_q));
        tg[0] = longint'($signed(r.tx)); tg[1] = longint'($signed(r.ty));
        tg[2] = longint'($signed(r.tz));
        v[0] = longint'($signed(r.vx)); v[1] = longint'($signed(r.vy));
        v[2] = longint'($signed(r.vz));
        sq = 0;
        for (i = 0; i < 3; i++)
        begin
            o = clamp32(tg[i] - c[i]);
            m = o < 0 ? -o : o;
            sq += m * m;
        end
        dist_v = root64(sq);
        spd = speed_q == 0 ? 1 : speed_q;
        t = (dist_v << 16) / spd;
        if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        maxm = 0;
        for (i = 0; i < 3; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            off = (m * t) >> 16;
            a[i] = tg[i] + (v[i] < 0 ? -longint'(off) : longint'(off)) - c[i];
            am[i] = a[i] < 0 ? -a[i] : a[i];
            if (am[i] > maxm) maxm = am[i];
        end
        s = 0;
        while ((maxm >> s) >= 64'h8000_0000) s++;
        sq = 0;
        for (i = 0; i < 3; i++)
        begin
            am[i] >>= s;
            sq += am[i] * am[i];
        end
        len = root64(sq);
        for (i = 0; i < 3; i++)
        begin
            o = 0;
            if (len != 0)
            begin
                o = longint'((am[i] * 16384 + len / 2) / len);
                if (a[i] < 0) o = -o;
            end
            if (i == 0) e.ax = o[15:0];
            else if (i == 1) e.ay = o[15:0];
            else e.az = o[15:0];
        end
        e.mz = c[2][31:0];
        e.dg = len == 0;
        return e;
    endfunction

    task automatic write_reg(input logic idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ltad_pkg::CFG_SPEED) speed_q = val;
        else height_q = val[15:0];
    endtask

    task automatic drain();
        target.valid <= 1'b0;
        @(posedge clk);
        while (expected_aims.size() != 0) @(posedge clk);
        repeat (160) @(posedge clk);
    endtask

    task automatic send(input req_t r, input logic chk, input aim_t want, input int gap);
        aim_t e;
        if (gap > 0)
        begin
            target.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        target.valid <= 1'b1;
        {target.target_valid, target.shooter_x, target.shooter_y, target.shooter_z,
         target.target_x, target.target_y, target.target_z,
         target.target_vx, target.target_vy, target.target_vz} <= r;
        do @(posedge clk); while (!target.ready);
        if (r.tv)
        begin
            e = predict_aim(r);
            if (chk && e != want)
                $display("note: table row disagrees with prediction");
            expected_aims.push_back(chk ? want : e);
        end
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 4096) - 2048;
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t rnd_req();
        req_t r;
        r.tv = $urandom_range(0, 9) != 0;
        r.sx = rnd32(); r.sy = rnd32(); r.sz = rnd32();
        r.tx = rnd32(); r.ty = rnd32(); r.tz = rnd32();
        r.vx = rnd32(); r.vy = rnd32(); r.vz = rnd32();
        if ($urandom_range(0, 15) == 0)
        begin
            r.tx = r.sx; r.ty = r.sy; r.tz = r.sz;
        end
        return r;
    endfunction

    // Result side: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (!rst_n)
            aim.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            aim.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            aim.ready <= $urandom_range(0, 3) == 0 ? 1'b0 : 1'b1;
        if (rst_n && aim.valid && aim.ready)
        begin
            n_results++;
            if (expected_aims.size() == 0)
            begin
                $display("unexpected result %0d", n_results);
                errors++;
            end
            else
            begin
                aim_t e;
                e = expected_aims.pop_front();
                if (aim.aim_x != e.ax) report("aim_x", $signed(aim.aim_x), $signed(e.ax));
                if (aim.aim_y != e.ay) report("aim_y", $signed(aim.aim_y), $signed(e.ay));
                if (aim.aim_z != e.az) report("aim_z", $signed(aim.aim_z), $signed(e.az));
                if (aim.muzzle_z != e.mz)
                    report("muzzle_z", $signed(aim.muzzle_z), $signed(e.mz));
                if (aim.degenerate != e.dg) report("degenerate", aim.degenerate, e.dg);
                if (e.dg) n_degenerate++;
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        req_t r;
        int i, k, lim;
        target.valid = 1'b0;
        {target.target_valid, target.shooter_x, target.shooter_y, target.shooter_z,
         target.target_x, target.target_y, target.target_z,
         target.target_vx, target.target_vy, target.target_vz} = '0;
        aim.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Shooter at the origin, target at the launch height: zero aim, launch height = reset height.
        rw.r = '0; rw.r.tv = 1'b1; rw.r.tz = 32'd25600; rw.chk = 1'b1;
        rw.e = '{ax: 16'd0, ay: 16'd0, az: 16'd0, mz: 32'd25600, dg: 1'b1};
        rows.push_back(rw);
        // Target straight up, standing still.
        rw.r = '0; rw.r.tv = 1'b1; rw.r.tz = 32'd1000000;
        rw.e = '{ax: 16'd0, ay: 16'd0, az: 16'd16384, mz: 32'd25600, dg: 1'b0};
        rows.push_back(rw);
        // Target along negative x, standing still.
        rw.r = '0; rw.r.tv = 1'b1; rw.r.tz = 32'd25600; rw.r.tx = -32'sd5000;
        rw.e = '{ax: -16'sd16384, ay: 16'd0, az: 16'd0, mz: 32'd25600, dg: 1'b0};
        rows.push_back(rw);
        // Launch height saturates at the top.
        rw.r = '0; rw.r.tv = 1'b1; rw.r.sz = 32'h7fff_ffff; rw.r.tz = 32'h7fff_ffff;
        rw.e = '{ax: 16'd0, ay: 16'd0, az: 16'd0, mz: 32'h7fff_ffff, dg: 1'b1};
        rows.push_back(rw);
        rw.chk = 1'b0;
        // No target: dropped.
        rw.r = '1; rw.r.tv = 1'b0; rows.push_back(rw);
        rw.r = '0; rows.push_back(rw);
        // Field extremes: opposite corners at full velocity, then mixed and still targets.
        rw.r = '{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        rows.push_back(rw);
        rw.r = '{1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        rows.push_back(rw);
        rw.r = '{1'b1, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        rows.push_back(rw);
        rw.r = '{1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0};
        rows.push_back(rw);

        foreach (rows[j]) send(rows[j].r, rows[j].chk, rows[j].e, $urandom_range(0, 3));
        drain();

        // Extreme, random and reset settings, including zero speed acting as the slowest.
        for (k = 0; k < 6; k++)
        begin
            case (k)
                0: begin write_reg(ltad_pkg::CFG_SPEED, 24'd0);
                    write_reg(ltad_pkg::CFG_MUZZLE, 24'hffff); end
                1: begin write_reg(ltad_pkg::CFG_SPEED, 24'hffffff);
                    write_reg(ltad_pkg::CFG_MUZZLE, 24'd0); end
                2: begin write_reg(ltad_pkg::CFG_SPEED, 24'd1);
                    write_reg(ltad_pkg::CFG_MUZZLE, 24'd1); end
                3: write_reg(ltad_pkg::CFG_SPEED, 24'($urandom_range(1, 24'hffffff)));
                4: write_reg(ltad_pkg::CFG_MUZZLE, 24'($urandom_range(0, 16'hffff)));
                default: begin write_reg(ltad_pkg::CFG_SPEED, ltad_pkg::SPEED_RESET);
                    write_reg(ltad_pkg::CFG_MUZZLE, 24'(ltad_pkg::MUZZLE_RESET)); end
            endcase
            lim = 140;
            for (i = 0; i < lim; i++)
            begin
                r = rnd_req();
                if (i == 20 && k == 1)
                    hold_off = 400;
                send(r, 1'b0, '0, (i % 40 < 10) ? 0 : $urandom_range(0, 3));
                if (i == 70)
                begin
                    target.valid <= 1'b0;
                    @(posedge clk);
                    while (expected_aims.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        $display("Covered %0d results (%0d degenerate) over six register settings.",
                 n_results, n_degenerate);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/ltad_pkg.sv
hdl/ltad_if.sv
hdl/ltad_isqrt.sv
hdl/ltad_tdiv.sv
hdl/ltad_ndiv.sv
hdl/lead_target_aim_direction.sv
hdl/ltad_checker.sv
bench/lead_target_aim_direction_tb.sv
